[hw/rtl/clrs_pkg.sv]
// Shared constants for the command line reset sequencer: ack codes,
// character codes, register indexes and reset defaults. No dependencies.
package clrs_pkg;

	localparam int LINE_CAPACITY_DEF = 16;

	localparam int TICK_W = 16;
	localparam int ACK_W  = 3;

	localparam logic [TICK_W-1:0] HOLD_TICKS_RST = 16'd100;
	localparam logic [TICK_W-1:0] BOOT_TICKS_RST = 16'd200;

	typedef enum logic [0:0] {
		REG_HOLD_TICKS = 1'b0,
		REG_BOOT_EXTRA = 1'b1
	} reg_index_t;

	typedef enum logic [0:0] {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} item_kind_t;

	typedef enum logic [ACK_W-1:0] {
		ACK_NONE  = 3'd0,
		ACK_RST   = 3'd1,
		ACK_BOOT  = 3'd2,
		ACK_RUN   = 3'd3,
		ACK_HELP  = 3'd4,
		ACK_STAT  = 3'd5,
		ACK_FLUSH = 3'd6
	} ack_t;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_B  = 8'h42;
	localparam logic [7:0] CH_E  = 8'h45;
	localparam logic [7:0] CH_F  = 8'h46;
	localparam logic [7:0] CH_H  = 8'h48;
	localparam logic [7:0] CH_L  = 8'h4C;
	localparam logic [7:0] CH_N  = 8'h4E;
	localparam logic [7:0] CH_O  = 8'h4F;
	localparam logic [7:0] CH_P  = 8'h50;
	localparam logic [7:0] CH_R  = 8'h52;
	localparam logic [7:0] CH_S  = 8'h53;
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_U  = 8'h55;

	localparam int HEAD_DEPTH = 5;

endpackage

[hw/rtl/command_line_reset_sequencer_top.sv]
// Command line reset sequencer, top level: line assembly, command match and
// the enable/boot pin sequencer in one registered pass.
// Depends on clrs_pkg.
//
// Channel | Dir | Payload (lowest bit first)                       | Handshake
// s_*     | in  | tdata: byte_in[7:0]; tuser: cmd (1 = tick)       | tvalid/tready
// m_*     | out | tdata: ack_code[2:0], enable_level, boot_pin_level,| tvalid/tready
//         |     |        flush_pulse, reset_busy, zero pad          |
// cfg_*   | in  | cfg_index selects register, cfg_data 16 bits     | cfg_we
//
// One transaction per cycle sustained while the result is not stalled; the result
// shows on m_tdata after the input register, then the result register.
// The rate is set by the single pass of compare and count logic between them.
// Reset is asynchronous, active low: pins come up high, sequencer idle, line
// empty, registers at 100 and 200 ticks. No clearing pass is needed.
// A stalled result holds the result register; the input register then takes
// one more transaction before s_tready drops.
module command_line_reset_sequencer_top #(
	parameter int LINE_CAPACITY = clrs_pkg::LINE_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tuser,   // [0] cmd: 0 host byte, 1 millisecond tick
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] ack_code, [3] enable_level,
	                               // [4] boot_pin_level, [5] flush_pulse,
	                               // [6] reset_busy, [7] zero
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import clrs_pkg::*;

	localparam int LEN_W = $clog2(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HOLD = 2'd1,
		PH_BOOT = 2'd2
	} phase_t;

	// Input stage
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;

	// Result register
	logic       out_valid_q;
	logic [7:0] out_data_q;

	// Block state
	logic [TICK_W-1:0] hold_ticks_q;
	logic [TICK_W-1:0] boot_extra_q;
	logic [7:0]        line_head_q [HEAD_DEPTH];
	logic [LEN_W-1:0]  len_q;
	logic              pending_q;
	logic              boot_mode_q;
	phase_t            phase_q;
	logic [TICK_W-1:0] elapsed_q;
	logic              enable_q;
	logic              boot_pin_q;

	// Next-state values
	logic [LEN_W-1:0]  len_d;
	logic              pending_d;
	logic              boot_mode_d;
	phase_t            phase_d;
	logic [TICK_W-1:0] elapsed_d;
	logic [TICK_W-1:0] elapsed_inc;
	logic              enable_d;
	logic              boot_pin_d;
	ack_t              ack_d;
	logic              flush_d;
	logic              head_we;
	logic              busy_d;
	logic              is_term;

	logic m_rst, m_boot, m_run, m_help, m_stat, m_flush;
	logic advance;

	// Move the input stage forward whenever the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Prefix match, guarded by the line length so unwritten head entries never count
	assign m_rst   = (len_q >= LEN_W'(3)) && line_head_q[0] == CH_R &&
	                 line_head_q[1] == CH_S && line_head_q[2] == CH_T;
	assign m_boot  = (len_q >= LEN_W'(4)) && line_head_q[0] == CH_B &&
	                 line_head_q[1] == CH_O && line_head_q[2] == CH_O &&
	                 line_head_q[3] == CH_T;
	assign m_run   = (len_q >= LEN_W'(3)) && line_head_q[0] == CH_R &&
	                 line_head_q[1] == CH_U && line_head_q[2] == CH_N;
	assign m_help  = (len_q >= LEN_W'(4)) && line_head_q[0] == CH_H &&
	                 line_head_q[1] == CH_E && line_head_q[2] == CH_L &&
	                 line_head_q[3] == CH_P;
	assign m_stat  = (len_q >= LEN_W'(4)) && line_head_q[0] == CH_S &&
	                 line_head_q[1] == CH_T && line_head_q[2] == CH_A &&
	                 line_head_q[3] == CH_T;
	assign m_flush = (len_q >= LEN_W'(5)) && line_head_q[0] == CH_F &&
	                 line_head_q[1] == CH_L && line_head_q[2] == CH_U &&
	                 line_head_q[3] == CH_S && line_head_q[4] == CH_H;

	assign is_term     = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
	// Saturate the elapsed count at all ones
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);

	always_comb begin
		len_d       = len_q;
		pending_d   = pending_q;
		boot_mode_d = boot_mode_q;
		phase_d     = phase_q;
		elapsed_d   = elapsed_q;
		enable_d    = enable_q;
		boot_pin_d  = boot_pin_q;
		ack_d       = ACK_NONE;
		flush_d     = 1'b0;
		head_we     = 1'b0;

		if (cmd_s1 == KIND_TICK) begin
			if (pending_q && phase_q == PH_IDLE) begin
				// Start a sequence: drive pins, restart the count, request a flush
				pending_d  = 1'b0;
				phase_d    = PH_HOLD;
				elapsed_d  = '0;
				boot_pin_d = !boot_mode_q;
				enable_d   = 1'b0;
				flush_d    = 1'b1;
			end else begin
				unique case (phase_q)
					PH_HOLD: begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc >= hold_ticks_q) begin
							enable_d = 1'b1;
							// Mode is sampled live at enable release
							if (boot_mode_q) begin
								phase_d   = PH_BOOT;
								elapsed_d = '0;
							end else begin
								phase_d = PH_IDLE;
								flush_d = 1'b1;
							end
						end
					end
					PH_BOOT: begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc >= boot_extra_q) begin
							boot_pin_d = 1'b1;
							phase_d    = PH_IDLE;
							flush_d    = 1'b1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end else if (is_term) begin
			if (len_q != '0) begin
				len_d = '0;
				if (m_rst) begin
					ack_d = ACK_RST;  boot_mode_d = 1'b0; pending_d = 1'b1;
				end else if (m_boot) begin
					ack_d = ACK_BOOT; boot_mode_d = 1'b1; pending_d = 1'b1;
				end else if (m_run) begin
					ack_d = ACK_RUN;  boot_mode_d = 1'b0; pending_d = 1'b1;
				end else if (m_help) begin
					ack_d = ACK_HELP;
				end else if (m_stat) begin
					ack_d = ACK_STAT;
				end else if (m_flush) begin
					ack_d   = ACK_FLUSH;
					flush_d = 1'b1;
				end
			end
		end else if (len_q < LEN_MAX) begin
			// Keep only the first characters; the rest just count
			head_we = (len_q < LEN_W'(HEAD_DEPTH));
			len_d   = len_q + LEN_W'(1);
		end else begin
			// Overlong line: drop it and this byte
			len_d = '0;
		end
	end

	assign busy_d = (phase_d == PH_HOLD) || (phase_d == PH_BOOT);

	// Control state, configuration and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			hold_ticks_q <= HOLD_TICKS_RST;
			boot_extra_q <= BOOT_TICKS_RST;
			len_q        <= '0;
			pending_q    <= 1'b0;
			boot_mode_q  <= 1'b0;
			phase_q      <= PH_IDLE;
			elapsed_q    <= '0;
			enable_q     <= 1'b1;
			boot_pin_q   <= 1'b1;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_HOLD_TICKS: hold_ticks_q <= cfg_data;
					REG_BOOT_EXTRA: boot_extra_q <= cfg_data;
					default: ;
				endcase
			end
			if (advance) begin
				len_q       <= len_d;
				pending_q   <= pending_d;
				boot_mode_q <= boot_mode_d;
				phase_q     <= phase_d;
				elapsed_q   <= elapsed_d;
				enable_q    <= enable_d;
				boot_pin_q  <= boot_pin_d;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
		if (advance && head_we) begin
			line_head_q[len_q[2:0]] <= byte_s1;
		end
		if (advance) begin
			out_data_q <= {1'b0, busy_d, flush_d, boot_pin_d, enable_d, ack_d};
		end
	end

	// Enable is only low while the hold phase runs
	assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |-> phase_q == PH_HOLD)
		else $error("enable low outside hold phase");

	// A tick never produces an ack code
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == KIND_TICK |=> out_data_q[ACK_W-1:0] == ACK_NONE)
		else $error("ack code on a tick");

	// FLUSH command always carries the flush request
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && ack_d == ACK_FLUSH |=> out_data_q[5])
		else $error("FLUSH ack without flush pulse");

endmodule

[bench/tb_command_line_reset_sequencer_top.sv]
// Self-checking bench for command_line_reset_sequencer_top: host bytes and ticks go in,
// each response is checked against a behavioral copy of line parsing and pin sequencing.
// Depends on clrs_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_command_line_reset_sequencer_top;

	import clrs_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HOLD = 2'd1,
		PH_BOOT = 2'd2
	} seq_phase_t;

	// m_tdata[6:0], highest field first
	typedef struct packed {
		logic reset_busy;
		logic flush_pulse;
		logic boot_pin_level;
		logic enable_level;
		ack_t ack_code;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// behavioral copy of the block state
	logic [7:0]      line_head [HEAD_DEPTH];
	int              line_len;
	logic            reset_requested;
	logic            boot_mode;
	seq_phase_t      phase;
	logic [15:0]     phase_ticks;
	logic            enable_pin;
	logic            boot_pin;
	logic [15:0]     hold_ticks;
	logic [15:0]     boot_extra_ticks;

	response_t       due_responses [$];
	int              items_accepted = 0;
	int              responses_seen = 0;
	int              mismatch_count = 0;
	int              send_gap_pct = 0;
	int              recv_gap_pct = 0;
	int              stall_left = 0;

	string           command_words [6] = '{"RST", "BOOT", "RUN", "HELP", "STAT", "FLUSH"};

	command_line_reset_sequencer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] byte_in
		.s_tuser   (s_tuser),   // [0] cmd: 0 host byte, 1 tick
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [2:0] ack, [3] enable, [4] boot, [5] flush, [6] busy
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Bail out if the run hangs; well above the slowest legal run.
	initial begin
		#30_000_000;
		$display("command_line_reset_sequencer_top regression: fail");
		$finish;
	end

	//------------------------------------------------------------------
	// Behavioral predictor
	//------------------------------------------------------------------
	function automatic void clear_model();
		for (int i = 0; i < HEAD_DEPTH; i++)
			line_head[i] = 8'h00;
		line_len         = 0;
		reset_requested  = 1'b0;
		boot_mode        = 1'b0;
		phase            = PH_IDLE;
		phase_ticks      = '0;
		enable_pin       = 1'b1;
		boot_pin         = 1'b1;
		hold_ticks       = HOLD_TICKS_RST;
		boot_extra_ticks = BOOT_TICKS_RST;
	endfunction

	// Prefix compare; a line shorter than the word never matches.
	function automatic bit line_starts_with(string word);
		int i;
		if (line_len < word.len())
			return 1'b0;
		for (i = 0; i < word.len(); i++)
			if (line_head[i] != word[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic ack_t match_command(ref logic flush);
		if (line_starts_with("RST")) begin
			boot_mode = 1'b0;
			reset_requested = 1'b1;
			return ACK_RST;
		end
		if (line_starts_with("BOOT")) begin
			boot_mode = 1'b1;
			reset_requested = 1'b1;
			return ACK_BOOT;
		end
		if (line_starts_with("RUN")) begin
			boot_mode = 1'b0;
			reset_requested = 1'b1;
			return ACK_RUN;
		end
		if (line_starts_with("HELP"))
			return ACK_HELP;
		if (line_starts_with("STAT"))
			return ACK_STAT;
		if (line_starts_with("FLUSH")) begin
			flush = 1'b1;
			return ACK_FLUSH;
		end
		return ACK_NONE;
	endfunction

	function automatic void advance_sequence(ref logic flush);
		if (reset_requested && phase == PH_IDLE) begin
			// launch: enable low, boot pin from the mode, tick counts from zero
			reset_requested = 1'b0;
			phase = PH_HOLD;
			phase_ticks = '0;
			boot_pin = !boot_mode;
			enable_pin = 1'b0;
			flush = 1'b1;
		end else if (phase == PH_HOLD || phase == PH_BOOT) begin
			if (phase_ticks != 16'hFFFF)
				phase_ticks++;
			if (phase == PH_HOLD) begin
				if (phase_ticks >= hold_ticks) begin
					enable_pin = 1'b1;
					// mode is read here, so a later command can still change it
					if (boot_mode) begin
						phase = PH_BOOT;
						phase_ticks = '0;
					end else begin
						phase = PH_IDLE;
						flush = 1'b1;
					end
				end
			end else if (phase_ticks >= boot_extra_ticks) begin
				boot_pin = 1'b1;
				phase = PH_IDLE;
				flush = 1'b1;
			end
		end else begin
			phase = PH_IDLE;
		end
	endfunction

	function automatic response_t sequencer_response(item_kind_t kind, logic [7:0] b);
		response_t r;
		logic      flush;
		ack_t      ack;
		flush = 1'b0;
		ack = ACK_NONE;
		if (kind == KIND_TICK) begin
			advance_sequence(flush);
		end else if (b == CH_CR || b == CH_LF) begin
			if (line_len > 0) begin
				ack = match_command(flush);
				line_len = 0;
			end
		end else if (line_len < LINE_CAPACITY_DEF - 1) begin
			if (line_len < HEAD_DEPTH)
				line_head[line_len] = b;
			line_len++;
		end else begin
			// overlong line: drop it along with this byte
			line_len = 0;
		end
		r.ack_code       = ack;
		r.enable_level   = enable_pin;
		r.boot_pin_level = boot_pin;
		r.flush_pulse    = flush;
		r.reset_busy     = (phase == PH_HOLD || phase == PH_BOOT);
		return r;
	endfunction

	//------------------------------------------------------------------
	// Scoreboard: predict on input transactions, check output transactions
	//------------------------------------------------------------------
	task automatic report_mismatch(string what, int due_v, int got_v);
		$display("mismatch at response %0d: %s expected %0d got %0d",
			responses_seen, what, due_v, got_v);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : track_responses
		response_t due;
		response_t seen;
		if (arst_n) begin
			// mirror register writes into the predictor
			if (cfg_we) begin
				if (cfg_index == REG_HOLD_TICKS)
					hold_ticks = cfg_data;
				else
					boot_extra_ticks = cfg_data;
			end
			// predict before checking so any latency works
			if (s_tvalid && s_tready)
				due_responses.push_back(sequencer_response(item_kind_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				seen = m_tdata[6:0];
				responses_seen++;
				if (due_responses.size() == 0) begin
					report_mismatch("unexpected response, data", 0, seen);
				end else begin
					due = due_responses.pop_front();
					if (seen.ack_code != due.ack_code)
						report_mismatch("ack_code", due.ack_code, seen.ack_code);
					if (seen.enable_level != due.enable_level)
						report_mismatch("enable_level", due.enable_level, seen.enable_level);
					if (seen.boot_pin_level != due.boot_pin_level)
						report_mismatch("boot_pin_level", due.boot_pin_level,
							seen.boot_pin_level);
					if (seen.flush_pulse != due.flush_pulse)
						report_mismatch("flush_pulse", due.flush_pulse, seen.flush_pulse);
					if (seen.reset_busy != due.reset_busy)
						report_mismatch("reset_busy", due.reset_busy, seen.reset_busy);
				end
			end
		end
	end

	// Receiver: a forced hold-off wins, otherwise random back-pressure.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	//------------------------------------------------------------------
	// Stimulus helpers
	//------------------------------------------------------------------
	// Offer one item and hold it until the transaction completes. Valid stays
	// high on return, so back-to-back items keep it high unless a send gap drops it.
	task automatic send_item(item_kind_t kind, logic [7:0] b);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_accepted++;
	endtask

	// Drop valid and hold until every response is back, then let the pipe settle.
	task automatic wait_for_responses();
		s_tvalid <= 1'b0;
		while (responses_seen != items_accepted)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timing(logic [15:0] hold, logic [15:0] extra);
		wait_for_responses();
		cfg_we    <= 1'b1;
		cfg_index <= REG_HOLD_TICKS;
		cfg_data  <= hold;
		@(posedge clk);
		cfg_index <= REG_BOOT_EXTRA;
		cfg_data  <= extra;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(KIND_TICK, 8'($urandom_range(255)));
	endtask

	task automatic send_line(string text, logic [7:0] term);
		int i;
		for (i = 0; i < text.len(); i++)
			send_item(KIND_BYTE, text[i]);
		send_item(KIND_BYTE, term);
	endtask

	function automatic logic [7:0] line_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] any_terminator();
		return $urandom_range(1) ? CH_CR : CH_LF;
	endfunction

	// A command word, now and then cut short, misspelt or with a tail.
	task automatic send_command_line();
		string      word;
		int         n_chars;
		int         bad_pos;
		int         i;
		logic [7:0] ch;
		word = command_words[$urandom_range(5)];
		n_chars = word.len();
		bad_pos = -1;
		case ($urandom_range(9))
			0: n_chars = $urandom_range(1, word.len() - 1);
			1: bad_pos = $urandom_range(word.len() - 1);
			default: ;
		endcase
		for (i = 0; i < n_chars; i++) begin
			ch = word[i];
			if (i == bad_pos)
				ch = CH_A + 8'($urandom_range(25));
			send_item(KIND_BYTE, ch);
		end
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, line_char());
		send_item(KIND_BYTE, any_terminator());
	endtask

	// Lines around the capacity: 15 characters survive, 16 or more are dropped.
	task automatic send_long_line();
		string word;
		int    n_chars;
		int    i;
		n_chars = $urandom_range(LINE_CAPACITY_DEF - 1, LINE_CAPACITY_DEF + 1);
		word = $urandom_range(1) ? command_words[$urandom_range(5)] : "";
		for (i = 0; i < n_chars; i++)
			send_item(KIND_BYTE, (i < word.len()) ? word[i] : line_char());
		send_item(KIND_BYTE, any_terminator());
	endtask

	task automatic send_random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			send_command_line();
		else if (pick < 75)
			send_ticks($urandom_range(1, 12));
		else if (pick < 85)
			repeat ($urandom_range(1, 6)) send_item(KIND_BYTE, 8'($urandom_range(255)));
		else if (pick < 92)
			send_long_line();
		else
			send_item(KIND_BYTE, any_terminator());
	endtask

	//------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------
	// Registers at their reset values: one bootloader sequence, 1 + 100 + 200 ticks.
	task automatic test_default_timing();
		send_line("BOOT", CH_CR);
		send_ticks(305);
	endtask

	// Every command, prefix match, empty, short and unknown lines, request while busy.
	task automatic test_command_set();
		set_timing(16'd1, 16'd1);
		send_line("RSTX", CH_CR);
		send_ticks(2);
		send_line("BOOT", CH_LF);
		send_ticks(1);
		// queue a normal reset behind the running bootloader sequence
		send_line("RUN", CH_CR);
		send_ticks(4);
		send_line("HELP", CH_LF);
		send_line("STAT", CH_CR);
		send_line("FLUSH", CH_CR);
		send_item(KIND_BYTE, CH_CR);
		send_line("RS", CH_CR);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, CH_LF);
		send_item(KIND_TICK, 8'hFF);
	endtask

	// Largest register values hold a bootloader sequence; then shorten each
	// phase below the running count so the next tick releases it.
	task automatic test_long_timing();
		set_timing(16'hFFFF, 16'hFFFF);
		send_line("BOOT", CH_LF);
		send_ticks(40);
		set_timing(16'd24, 16'hFFFF);
		send_ticks(30);
		set_timing(16'd24, 16'd20);
		send_ticks(3);
	endtask

	// Stall the output long enough to back up the pipe while items keep coming.
	task automatic test_output_stall();
		int first;
		first = items_accepted;
		stall_left = 300;
		while (items_accepted - first < 40)
			send_random_sequence();
		// pause the sender until everything has drained
		wait_for_responses();
	endtask

	task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
		int first;
		send_gap_pct = send_pct;
		recv_gap_pct = recv_pct;
		first = items_accepted;
		while (items_accepted - first < n_items)
			send_random_sequence();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tuser   = KIND_BYTE;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_HOLD_TICKS;
		cfg_data  = '0;
		clear_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_timing();
		test_command_set();
		test_long_timing();

		// sender mostly busy, receiver often stalling
		set_timing(16'd3, 16'd5);
		send_gap_pct = 11;
		recv_gap_pct = 56;
		test_output_stall();
		test_random_traffic(250, 11, 56);

		// roles swapped
		set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
		test_random_traffic(250, 56, 11);

		// full rate both ways
		set_timing(16'd2, 16'd1);
		test_random_traffic(255, 0, 0);

		wait_for_responses();
		repeat (8) @(posedge clk);
		if (due_responses.size() != 0)
			report_mismatch("responses never delivered, count", 0, due_responses.size());
		if (mismatch_count == 0)
			$display("command_line_reset_sequencer_top regression: pass");
		else
			$display("command_line_reset_sequencer_top regression: fail");
		$finish;
	end

endmodule
